### hdl/rmfw_pkg.sv
`default_nettype none
package rmfw_pkg;

    localparam int unsigned TID_W    = 4;
    localparam int unsigned STATUS_W = 3;
    localparam int unsigned ERR_W    = 2;
    localparam int unsigned NEST_W   = 8;

    localparam logic OP_ACQUIRE = 1'b0;
    localparam logic OP_RELEASE = 1'b1;

    localparam logic [STATUS_W-1:0] STS_GRANTED    = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NESTED     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_QUEUED     = 3'd2;
    localparam logic [STATUS_W-1:0] STS_COUNT_DOWN = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FREED      = 3'd4;
    localparam logic [STATUS_W-1:0] STS_HANDED     = 3'd5;
    localparam logic [STATUS_W-1:0] STS_NOT_HOLDER = 3'd6;
    localparam logic [STATUS_W-1:0] STS_OTHER      = 3'd7;

    localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
    localparam logic [ERR_W-1:0] ERR_WAITING   = 2'd1;
    localparam logic [ERR_W-1:0] ERR_SATURATED = 2'd2;

    typedef enum logic {
        ST_IDLE,
        ST_EXEC
    } t_state;

    typedef struct packed {
        logic             op;
        logic [TID_W-1:0] thread_id;
    } t_req;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ERR_W-1:0]    error_kind;
        logic                woken_valid;
        logic [TID_W-1:0]    woken_thread;
        logic                owner_valid;
        logic [TID_W-1:0]    owner_id;
        logic [NEST_W-1:0]   nest_count;
    } t_result;

endpackage
`default_nettype wire

### hdl/rmfw_req_if.sv
`default_nettype none
interface rmfw_req_if;
    logic                     valid;
    logic                     ready;
    logic                     op;
    logic [rmfw_pkg::TID_W-1:0] thread_id;

    modport source(output valid, output op, output thread_id, input ready);
    modport sink(input valid, input op, input thread_id, output ready);
endinterface
`default_nettype wire

### hdl/rmfw_rsp_if.sv
`default_nettype none
interface rmfw_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [rmfw_pkg::STATUS_W-1:0] status;
    logic [rmfw_pkg::ERR_W-1:0]    error_kind;
    logic                          woken_valid;
    logic [rmfw_pkg::TID_W-1:0]    woken_thread;
    logic                          owner_valid;
    logic [rmfw_pkg::TID_W-1:0]    owner_id;
    logic [rmfw_pkg::NEST_W-1:0]   nest_count;

    modport source(output valid, output status, output error_kind, output woken_valid,
                   output woken_thread, output owner_valid, output owner_id,
                   output nest_count, input ready);
    modport sink(input valid, input status, input error_kind, input woken_valid,
                 input woken_thread, input owner_valid, input owner_id,
                 input nest_count, output ready);
endinterface
`default_nettype wire

### hdl/recursive_mutex_fifo_waiters.sv
// Recursive mutex with a FIFO of waiting threads.
// i_req (sink): one beat per request, op (acquire/release) and thread_id.
// o_rsp (source): one beat per request with status, error kind, the woken
// thread on handover, and the owner and nest count after the request.
// A request is registered when taken and evaluated once the head
// entry of the waiter RAM has been read; the result then lands in an output
// register. The block does not take a new request until the current one
// has been evaluated, since i_req ready is high only in the idle state.
// The output register holds a finished result while the next request is
// already taken; if o_rsp stalls, evaluation of that request waits until the
// register frees up, and i_req ready stays low meanwhile.
// Synchronous reset frees the mutex, empties the queue and clears all
// waiting flags; waiter RAM contents are not cleared and need no sweep.
`default_nettype none
module recursive_mutex_fifo_waiters #(
    parameter int unsigned THREADS    = 16,
    parameter int unsigned COUNT_BITS = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rmfw_req_if.sink      i_req,
    rmfw_rsp_if.source    o_rsp
);

    rmfw_pkg::t_req    req;
    rmfw_pkg::t_result res;
    rmfw_pkg::t_result r_out;
    logic              r_out_valid;
    logic              res_valid;
    logic              res_ready;

    assign req.op        = i_req.op;
    assign req.thread_id = i_req.thread_id;

    // Output register frees when empty or when its beat leaves this cycle.
    assign res_ready = !r_out_valid || o_rsp.ready;

    rmfw_ctrl #(
        .THREADS   (THREADS),
        .COUNT_BITS(COUNT_BITS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_valid(i_req.valid),
        .i_req      (req),
        .o_req_ready(i_req.ready),
        .o_res_valid(res_valid),
        .o_res      (res),
        .i_res_ready(res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_rsp.valid        = r_out_valid;
    assign o_rsp.status       = r_out.status;
    assign o_rsp.error_kind   = r_out.error_kind;
    assign o_rsp.woken_valid  = r_out.woken_valid;
    assign o_rsp.woken_thread = r_out.woken_thread;
    assign o_rsp.owner_valid  = r_out.owner_valid;
    assign o_rsp.owner_id     = r_out.owner_id;
    assign o_rsp.nest_count   = r_out.nest_count;

endmodule
`default_nettype wire

### hdl/rmfw_ram.sv
`default_nettype none
module rmfw_ram #(
    parameter int unsigned WIDTH = 4,
    parameter int unsigned DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

### hdl/rmfw_ctrl.sv
`default_nettype none
module rmfw_ctrl #(
    parameter int unsigned THREADS    = 16,
    parameter int unsigned COUNT_BITS = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_req_valid,
    input  wire rmfw_pkg::t_req    i_req,
    output logic                   o_req_ready,
    output logic                   o_res_valid,
    output rmfw_pkg::t_result      o_res,
    input  wire logic              i_res_ready
);

    localparam int unsigned TW = $clog2(THREADS);
    localparam int unsigned IW = (TW > rmfw_pkg::TID_W) ? TW : rmfw_pkg::TID_W;
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

    rmfw_pkg::t_state r_state, n_state;
    rmfw_pkg::t_req   r_req;

    logic                  r_held, n_held;
    logic [TW-1:0]         r_holder, n_holder;
    logic [COUNT_BITS-1:0] r_count, n_count;
    logic [TW-1:0]         r_head, n_head;
    logic [TW-1:0]         r_tail, n_tail;
    logic [TW:0]           r_fill, n_fill;
    logic [THREADS-1:0]    r_waiting, n_waiting;

    logic          accept;
    logic          done;
    logic          enq;
    logic [TW-1:0] head_tid;
    logic [IW-1:0] tid_ext;
    logic [TW-1:0] tid;
    logic          tid_ok;
    logic [rmfw_pkg::STATUS_W-1:0] status;
    logic [rmfw_pkg::ERR_W-1:0]    err;
    logic                          woken_v;

    assign tid_ext = IW'(r_req.thread_id);
    assign tid     = tid_ext[TW-1:0];
    assign tid_ok  = 32'(r_req.thread_id) < THREADS;

    // Waiter queue storage; read port follows the head pointer.
    rmfw_ram #(
        .WIDTH(TW),
        .DEPTH(THREADS)
    ) u_wait_ram (
        .i_clk  (i_clk),
        .i_we   (enq),
        .i_waddr(r_tail),
        .i_wdata(tid),
        .i_raddr(r_head),
        .o_rdata(head_tid)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            rmfw_pkg::ST_IDLE: if (i_req_valid) n_state = rmfw_pkg::ST_EXEC;
            rmfw_pkg::ST_EXEC: if (i_res_ready) n_state = rmfw_pkg::ST_IDLE;
            default:           n_state = rmfw_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_req_ready = 1'b0;
        o_res_valid = 1'b0;
        unique case (r_state)
            rmfw_pkg::ST_IDLE: o_req_ready = 1'b1;
            rmfw_pkg::ST_EXEC: o_res_valid = 1'b1;
            default: begin
                o_req_ready = 1'b0;
                o_res_valid = 1'b0;
            end
        endcase
    end

    assign accept = o_req_ready && i_req_valid;
    assign done   = o_res_valid && i_res_ready;

    always_comb begin
        n_held    = r_held;
        n_holder  = r_holder;
        n_count   = r_count;
        n_head    = r_head;
        n_tail    = r_tail;
        n_fill    = r_fill;
        n_waiting = r_waiting;
        status    = rmfw_pkg::STS_OTHER;
        err       = rmfw_pkg::ERR_NONE;
        woken_v   = 1'b0;
        enq       = 1'b0;
        priority if (!tid_ok) begin
            status = rmfw_pkg::STS_OTHER;
        end else if (r_req.op == rmfw_pkg::OP_ACQUIRE) begin
            priority if (!r_held) begin
                n_held   = 1'b1;
                n_holder = tid;
                n_count  = COUNT_BITS'(1);
                status   = rmfw_pkg::STS_GRANTED;
            end else if (r_holder == tid) begin
                if (r_count == COUNT_MAX) begin
                    err = rmfw_pkg::ERR_SATURATED;
                end else begin
                    n_count = r_count + 1'b1;
                    status  = rmfw_pkg::STS_NESTED;
                end
            end else if (r_waiting[tid]) begin
                err = rmfw_pkg::ERR_WAITING;
            end else if (r_fill == (TW+1)'(THREADS)) begin
                status = rmfw_pkg::STS_OTHER;
            end else begin
                enq            = done;
                n_tail         = (r_tail == TW'(THREADS - 1)) ? '0 : r_tail + 1'b1;
                n_fill         = r_fill + 1'b1;
                n_waiting[tid] = 1'b1;
                status         = rmfw_pkg::STS_QUEUED;
            end
        end else begin
            priority if (!r_held || r_holder != tid) begin
                status = rmfw_pkg::STS_NOT_HOLDER;
            end else if (r_count > COUNT_BITS'(1)) begin
                n_count = r_count - 1'b1;
                status  = rmfw_pkg::STS_COUNT_DOWN;
            end else if (r_fill != '0) begin
                // Hand over straight to the oldest waiter.
                n_head              = (r_head == TW'(THREADS - 1)) ? '0 : r_head + 1'b1;
                n_fill              = r_fill - 1'b1;
                n_waiting[head_tid] = 1'b0;
                n_holder            = head_tid;
                n_count             = COUNT_BITS'(1);
                woken_v             = 1'b1;
                status              = rmfw_pkg::STS_HANDED;
            end else begin
                n_held   = 1'b0;
                n_holder = '0;
                n_count  = '0;
                status   = rmfw_pkg::STS_FREED;
            end
        end
    end

    always_comb begin
        o_res.status       = status;
        o_res.error_kind   = err;
        o_res.woken_valid  = woken_v;
        o_res.woken_thread = woken_v ? rmfw_pkg::TID_W'(head_tid) : '0;
        o_res.owner_valid  = n_held;
        o_res.owner_id     = n_held ? rmfw_pkg::TID_W'(n_holder) : '0;
        o_res.nest_count   = n_held ? rmfw_pkg::NEST_W'(n_count) : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= rmfw_pkg::ST_IDLE;
            r_held    <= 1'b0;
            r_holder  <= '0;
            r_count   <= '0;
            r_head    <= '0;
            r_tail    <= '0;
            r_fill    <= '0;
            r_waiting <= '0;
        end else begin
            r_state <= n_state;
            if (done) begin
                r_held    <= n_held;
                r_holder  <= n_holder;
                r_count   <= n_count;
                r_head    <= n_head;
                r_tail    <= n_tail;
                r_fill    <= n_fill;
                r_waiting <= n_waiting;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req <= i_req;
        end
    end

endmodule
`default_nettype wire
